// File: rtl/b2d_pkg.sv
package b2d_pkg;

  localparam int unsigned ValueW        = 64;
  localparam int unsigned DigitW        = 6;
  localparam int unsigned NumDigits     = 20;
  localparam int unsigned NibbleW       = 4;
  localparam int unsigned BcdW          = NumDigits * NibbleW;
  localparam int unsigned StepsPerCycle = 4;
  localparam int unsigned ConvCycles    = ValueW / StepsPerCycle;
  localparam int unsigned CntW          = $clog2(ConvCycles);
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned QPtrW         = $clog2(QueueDepth);
  localparam int unsigned QCntW         = $clog2(QueueDepth + 1);

  localparam logic [DigitW-1:0]  AsciiZero = 6'd48;
  localparam logic [NibbleW-1:0] BcdFive   = 4'd5;
  localparam logic [NibbleW-1:0] BcdThree  = 4'd3;

  typedef logic [BcdW-1:0] bcd_t;

  // one converted number travelling between front, queue and back
  typedef struct packed {
    logic valid;
    bcd_t bcd;
  } bcd_req_t;

  // add-3 correction on every decimal digit before the next shift
  function automatic bcd_t bcd_adjust(input bcd_t b);
    bcd_t r;
    r = b;
    for (int i = 0; i < NumDigits; i++) begin
      if (b[i*NibbleW +: NibbleW] >= BcdFive) begin
        r[i*NibbleW +: NibbleW] = b[i*NibbleW +: NibbleW] + BcdThree;
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/b2d_conv.sv
module b2d_conv import b2d_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ValueW-1:0] value_i,
  output bcd_req_t          push_o,
  input  logic              push_ready_i
);

  typedef enum logic [1:0] {
    ConvIdle,
    ConvRun,
    ConvPush
  } conv_state_e;

  conv_state_e       state_q;
  logic [CntW-1:0]   cnt_q;
  bcd_t              bcd_q;
  bcd_t              bcd_d;
  logic [ValueW-1:0] bin_q;
  logic [ValueW-1:0] bin_d;

  // shift-and-add-3, StepsPerCycle bits per cycle
  always_comb begin
    bcd_d = bcd_q;
    bin_d = bin_q;
    for (int s = 0; s < StepsPerCycle; s++) begin
      bcd_d = bcd_adjust(bcd_d);
      bcd_d = {bcd_d[BcdW-2:0], bin_d[ValueW-1]};
      bin_d = {bin_d[ValueW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ConvIdle;
      cnt_q   <= '0;
      bcd_q   <= '0;
      bin_q   <= '0;
    end else begin
      unique case (state_q)
        ConvIdle: begin
          if (in_valid_i) begin
            bin_q   <= value_i;
            bcd_q   <= '0;
            cnt_q   <= '0;
            state_q <= ConvRun;
          end
        end
        ConvRun: begin
          bin_q <= bin_d;
          bcd_q <= bcd_d;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(ConvCycles - 1)) begin
            state_q <= ConvPush;
          end
        end
        ConvPush: begin
          if (push_ready_i) begin
            state_q <= ConvIdle;
          end
        end
        default: state_q <= ConvIdle;
      endcase
    end
  end

  assign in_ready_o   = (state_q == ConvIdle);
  assign push_o.valid = (state_q == ConvPush);
  assign push_o.bcd   = bcd_q;

endmodule

// File: rtl/b2d_queue.sv
module b2d_queue import b2d_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  bcd_req_t push_i,
  output logic     push_ready_o,
  output bcd_req_t pop_o,
  input  logic     pop_i
);

  bcd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = (count_q != QCntW'(QueueDepth));
  assign do_push      = push_i.valid && push_ready_o;
  assign do_pop       = pop_i && pop_o.valid;

  assign pop_o.valid = (count_q != '0);
  assign pop_o.bcd   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.bcd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/b2d_emit.sv
module b2d_emit import b2d_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bcd_req_t          pop_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DigitW-1:0] digit_char_o,
  output logic              last_digit_o
);

  bcd_t cur_q;
  logic valid_q;
  logic last;

  // no nonzero digit above the current one
  assign last  = (cur_q[BcdW-1:NibbleW] == '0);
  assign pop_o = pop_i.valid && (!valid_q || (out_ready_i && last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cur_q   <= '0;
    end else begin
      if (pop_o) begin
        cur_q   <= pop_i.bcd;
        valid_q <= 1'b1;
      end else if (valid_q && out_ready_i) begin
        if (last) begin
          valid_q <= 1'b0;
        end else begin
          cur_q <= {{NibbleW{1'b0}}, cur_q[BcdW-1:NibbleW]};
        end
      end
    end
  end

  assign out_valid_o  = valid_q;
  assign digit_char_o = AsciiZero + DigitW'(cur_q[NibbleW-1:0]);
  assign last_digit_o = last;

endmodule

// File: rtl/binary_to_decimal_digits_u64.sv
// binary to decimal digit converter for 64-bit unsigned values
//
// input channel: in_valid_i / in_ready_o carry value_i, one number per request
// output channel: out_valid_o / out_ready_i carry digit_char_o (ascii '0'..'9')
// and last_digit_o; a number comes out as 1 to 20 requests, least significant
// digit first, leading zeros dropped, zero giving a single '0'
// last_digit_o marks the most significant digit and closes the run
//
// the front converts by shift-and-add-3, four bits per cycle, then holds each
// number until the queue takes it, and takes no new one before that; the back
// sends one digit per cycle while it has a digit and out_ready_i is high
// a two-entry queue of converted numbers sits between them
// the first digit is valid once the back has loaded the number from the queue
//
// a stalled receiver holds the current digit; the front keeps converting and
// fills the queue, then holds in_ready_o low
// reset empties the queue and drops any run in flight
module binary_to_decimal_digits_u64 import b2d_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ValueW-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DigitW-1:0] digit_char_o,
  output logic              last_digit_o
);

  bcd_req_t push;
  logic     push_ready;
  bcd_req_t pop_data;
  logic     pop;

  b2d_conv u_conv (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  b2d_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .pop_o        (pop_data),
    .pop_i        (pop)
  );

  b2d_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_i        (pop_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

endmodule

// File: rtl/b2d_checker.sv
module b2d_checker import b2d_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [DigitW-1:0] digit_char_o,
  input logic              last_digit_o
);

  // a held digit is not withdrawn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output request dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_char_o >= AsciiZero) && (digit_char_o <= AsciiZero + 6'd9))
    else $error("digit outside ascii range");

  // a run does not break before its last digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_digit_o |=> out_valid_o)
    else $error("digit run broke before its last digit");

  // the front is busy converting right after it takes a number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again during conversion");

endmodule

bind binary_to_decimal_digits_u64 b2d_checker u_b2d_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .digit_char_o (digit_char_o),
  .last_digit_o (last_digit_o)
);
